@@ rtl/core/stereo_biquad_highpass_macros.svh @@
// ----------------------------------------------------------------------------
// stereo_biquad_highpass_macros.svh
// Assertion macros shared by the stereo biquad high-pass RTL.
// ----------------------------------------------------------------------------
`ifndef STEREO_BIQUAD_HIGHPASS_MACROS_SVH
`define STEREO_BIQUAD_HIGHPASS_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define SBHP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define SBHP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/sbhp_pkg.sv @@
// ----------------------------------------------------------------------------
// sbhp_pkg
// Types and fixed constants of the stereo biquad high-pass filter.
// ----------------------------------------------------------------------------
package sbhp_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   // Output queue depth; a power of two so the pointers wrap on their own
   localparam int OUT_DEPTH  = 4;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BYPASS  = 3'd0,
      CSR_COEF_B0 = 3'd1,
      CSR_COEF_B1 = 3'd2,
      CSR_COEF_B2 = 3'd3,
      CSR_COEF_A1 = 3'd4,
      CSR_COEF_A2 = 3'd5
   } csr_index_type;

   typedef struct packed {
      sample_type left_in;
      sample_type right_in;
      logic       stereo;
   } req_payload_type;

   typedef struct packed {
      sample_type left_out;
      sample_type right_out;
   } rsp_payload_type;

   typedef struct packed {
      coef_type b0;
      coef_type b1;
      coef_type b2;
      coef_type a1;
      coef_type a2;
   } coef_set_type;

   // Per-lane control that travels with a transaction
   typedef struct packed {
      logic valid;
      logic filt_en;
   } lane_ctl_type;

   // Per-lane result handed to the merge stage
   typedef struct packed {
      logic       valid;
      sample_type sample;
   } lane_res_type;

endpackage

@@ rtl/core/stereo_biquad_highpass.sv @@
// ----------------------------------------------------------------------------
// stereo_biquad_highpass
// Stereo second-order high-pass section, direct form I, fixed point. One
// lane per channel, results merged into an output queue.
//
//   channel   ports                          moves
//   request   req_valid/req_ready/req_data   one stereo frame
//   response  rsp_valid/rsp_ready/rsp_data   one filtered frame
//   csr       csr_we/csr_index/csr_wdata     one register write
//
// One frame per cycle sustained while req_ready is high; results pass through
// the lane registers into the output queue. The loop that sets the rate is the
// feedback multiply-accumulate of each lane, closing on the output history registers.
// A four-entry output queue with credit count decouples the sides: req_ready
// drops only when four transactions are outstanding.
// Synchronous reset clears history, pipeline valids and the queue; it sets bypass and a unity b0.
// ----------------------------------------------------------------------------
module stereo_biquad_highpass #(
   parameter int COEF_FRAC_BITS = 30
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sbhp_pkg::req_payload_type             req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sbhp_pkg::rsp_payload_type             rsp_data,
   input  logic                                  csr_we,
   input  logic [sbhp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sbhp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import sbhp_pkg::*;

   localparam coef_type COEF_UNITY = COEF_W'(1) << COEF_FRAC_BITS;

   logic         bypass_ff, bypass_in;
   coef_set_type coef_ff, coef_in;
   logic         req_accept;
   lane_ctl_type ctl_l, ctl_r;
   lane_res_type res_l, res_r;

   // Decode register writes
   always_comb begin
      bypass_in = bypass_ff;
      coef_in   = coef_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BYPASS:  bypass_in  = csr_wdata[0];
            CSR_COEF_B0: coef_in.b0 = csr_wdata[COEF_W-1:0];
            CSR_COEF_B1: coef_in.b1 = csr_wdata[COEF_W-1:0];
            CSR_COEF_B2: coef_in.b2 = csr_wdata[COEF_W-1:0];
            CSR_COEF_A1: coef_in.a1 = csr_wdata[COEF_W-1:0];
            CSR_COEF_A2: coef_in.a2 = csr_wdata[COEF_W-1:0];
            default: begin
               bypass_in = bypass_ff;
               coef_in   = coef_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b1;
         coef_ff   <= '{b0: COEF_UNITY, b1: '0, b2: '0, a1: '0, a2: '0};
      end else begin
         bypass_ff <= bypass_in;
         coef_ff   <= coef_in;
      end
   end

   // Steer each lane: left filters unless bypassed, right also needs stereo
   assign req_accept    = req_valid && req_ready;
   assign ctl_l.valid   = req_accept;
   assign ctl_l.filt_en = !bypass_ff;
   assign ctl_r.valid   = req_accept;
   assign ctl_r.filt_en = !bypass_ff && req_data.stereo;

   sbhp_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_l (
      .clock  (clock),
      .reset  (reset),
      .in_ctl (ctl_l),
      .in_x   (req_data.left_in),
      .coef   (coef_ff),
      .res    (res_l)
   );

   sbhp_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_r (
      .clock  (clock),
      .reset  (reset),
      .in_ctl (ctl_r),
      .in_x   (req_data.right_in),
      .coef   (coef_ff),
      .res    (res_r)
   );

   sbhp_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_ready  (req_ready),
      .lane_l     (res_l),
      .lane_r     (res_r),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

@@ rtl/core/sbhp_lane.sv @@
// ----------------------------------------------------------------------------
// sbhp_lane
// One channel of the direct form I biquad: feedforward products, feedforward
// sum, then the feedback multiply-accumulate with round and saturate.
// ----------------------------------------------------------------------------
`include "stereo_biquad_highpass_macros.svh"

module sbhp_lane #(
   parameter int COEF_FRAC_BITS = 30
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sbhp_pkg::lane_ctl_type in_ctl,
   input  sbhp_pkg::sample_type   in_x,
   input  sbhp_pkg::coef_set_type coef,
   output sbhp_pkg::lane_res_type res
);
   import sbhp_pkg::*;

   localparam int PROD_W = COEF_W + SAMPLE_W;
   localparam int ACC_W  = PROD_W + 3;
   localparam logic signed [ACC_W-1:0] RND_CONST = ACC_W'(1) << (COEF_FRAC_BITS - 1);

   sample_type x_hist_ff [2];
   sample_type x_hist_in [2];
   sample_type y_hist_ff [2];
   sample_type y_hist_in [2];

   lane_ctl_type s1_ctl_ff;
   sample_type   s1_x_ff;
   logic signed [PROD_W-1:0] s1_pb0_ff, s1_pb1_ff, s1_pb2_ff;

   lane_ctl_type s2_ctl_ff;
   sample_type   s2_x_ff;
   logic signed [ACC_W-1:0] s2_sum_ff;

   logic signed [PROD_W-1:0] pb0, pb1, pb2, pa1, pa2;
   logic signed [ACC_W-1:0]  acc, acc_shr;
   logic [ACC_W-SAMPLE_W:0]  acc_top;
   sample_type               y_sat;

   // Feedforward products against the input history
   assign pb0 = PROD_W'(coef.b0) * PROD_W'(in_x);
   assign pb1 = PROD_W'(coef.b1) * PROD_W'(x_hist_ff[0]);
   assign pb2 = PROD_W'(coef.b2) * PROD_W'(x_hist_ff[1]);

   // Shift the input history on a filtered transaction, hold otherwise
   always_comb begin
      x_hist_in = x_hist_ff;
      if (in_ctl.valid && in_ctl.filt_en) begin
         x_hist_in[0] = in_x;
         x_hist_in[1] = x_hist_ff[0];
      end
   end

   // Stage 1: register the products
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff    <= '0;
         x_hist_ff[0] <= '0;
         x_hist_ff[1] <= '0;
      end else begin
         s1_ctl_ff <= in_ctl;
         x_hist_ff <= x_hist_in;
      end
      s1_x_ff   <= in_x;
      s1_pb0_ff <= pb0;
      s1_pb1_ff <= pb1;
      s1_pb2_ff <= pb2;
   end

   // Stage 2: sum the feedforward terms with the rounding offset
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s1_ctl_ff;
      end
      s2_x_ff   <= s1_x_ff;
      s2_sum_ff <= ACC_W'(s1_pb0_ff) + ACC_W'(s1_pb1_ff) + ACC_W'(s1_pb2_ff) + RND_CONST;
   end

   // Stage 3: close the feedback loop, round and saturate
   assign pa1     = PROD_W'(coef.a1) * PROD_W'(y_hist_ff[0]);
   assign pa2     = PROD_W'(coef.a2) * PROD_W'(y_hist_ff[1]);
   assign acc     = s2_sum_ff - ACC_W'(pa1) - ACC_W'(pa2);
   assign acc_shr = acc >>> COEF_FRAC_BITS;
   assign acc_top = acc_shr[ACC_W-1:SAMPLE_W-1];

   always_comb begin
      priority if ((&acc_top) || !(|acc_top)) begin
         y_sat = acc_shr[SAMPLE_W-1:0];
      end else if (acc_shr[ACC_W-1]) begin
         y_sat = SAMPLE_MIN;
      end else begin
         y_sat = SAMPLE_MAX;
      end
   end

   // Pass the sample unchanged when this lane does not filter
   assign res.valid  = s2_ctl_ff.valid;
   assign res.sample = s2_ctl_ff.filt_en ? y_sat : s2_x_ff;

   // Shift the output history on a filtered transaction, hold otherwise
   always_comb begin
      y_hist_in = y_hist_ff;
      if (s2_ctl_ff.valid && s2_ctl_ff.filt_en) begin
         y_hist_in[0] = y_sat;
         y_hist_in[1] = y_hist_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_hist_ff[0] <= '0;
         y_hist_ff[1] <= '0;
      end else begin
         y_hist_ff <= y_hist_in;
      end
   end

   `SBHP_ASSERT_NEXT(a_xhist_hold, clock, reset, !(in_ctl.valid && in_ctl.filt_en), $stable(x_hist_ff[0]) && $stable(x_hist_ff[1]), "input history moved without a filtered transaction")
   `SBHP_ASSERT_NEXT(a_yhist_hold, clock, reset, !(s2_ctl_ff.valid && s2_ctl_ff.filt_en), $stable(y_hist_ff[0]) && $stable(y_hist_ff[1]), "output history moved without a filtered transaction")
   `SBHP_ASSERT_NEXT(a_yhist_shift, clock, reset, s2_ctl_ff.valid && s2_ctl_ff.filt_en, (y_hist_ff[0] == $past(res.sample)) && (y_hist_ff[1] == $past(y_hist_ff[0])), "output history does not hold the delivered sample")

endmodule

@@ rtl/core/sbhp_merge.sv @@
// ----------------------------------------------------------------------------
// sbhp_merge
// Joins the two lane results into one response and queues it, with a credit
// count that keeps the queue from overflowing.
// ----------------------------------------------------------------------------
`include "stereo_biquad_highpass_macros.svh"

module sbhp_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_accept,
   output logic                     req_ready,
   input  sbhp_pkg::lane_res_type    lane_l,
   input  sbhp_pkg::lane_res_type    lane_r,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sbhp_pkg::rsp_payload_type rsp_data
);
   import sbhp_pkg::*;

   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   rsp_payload_type  fifo_ff [OUT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] pend_ff, pend_in;
   logic             push, pop;

   assign push = lane_l.valid;
   assign pop  = rsp_valid && rsp_ready;

   // Take a transaction only if a queue slot is promised to it
   assign req_ready = pend_ff < CNT_W'(OUT_DEPTH);
   assign rsp_valid = fill_ff != '0;
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   // Advance pointers and counts
   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = CNT_W'(fill_ff + CNT_W'(push) - CNT_W'(pop));
      pend_in   = CNT_W'(pend_ff + CNT_W'(req_accept) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         pend_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         pend_ff   <= pend_in;
      end
   end

   // Write the merged lane results into the queue
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= '{left_out: lane_l.sample, right_out: lane_r.sample};
      end
   end

   `SBHP_ASSERT_SAME(a_lane_lockstep, clock, reset, 1'b1, lane_l.valid == lane_r.valid, "lanes out of step")
   `SBHP_ASSERT_SAME(a_fifo_room, clock, reset, push, fill_ff < CNT_W'(OUT_DEPTH), "result written into a full queue")
   `SBHP_ASSERT_SAME(a_fill_le_pend, clock, reset, 1'b1, fill_ff <= pend_ff, "queue holds more than the outstanding transactions")

endmodule
